### src/flpte_pkg.sv
// Shared constants, codes and entry helpers for the four-level page table engine.
`timescale 1ns / 1ps
`default_nettype none

package flpte_pkg;

    // Store geometry
    localparam int NUM_FRAMES        = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int FRAME_W           = $clog2(NUM_FRAMES);
    localparam int ADDR_W            = FRAME_W + IDX_W;
    localparam int NF_MAX            = (NUM_FRAMES > 16) ? NUM_FRAMES : 16;
    localparam int NF_W              = $clog2(NF_MAX + 1);

    // Field widths
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FN_W    = 40;
    localparam int ENTRY_W = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

    // Request codes
    localparam logic [1:0] REQ_TRANSLATE = 2'd0;
    localparam logic [1:0] REQ_MAP       = 2'd1;
    localparam logic [1:0] REQ_UNMAP     = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_ALREADY    = 2'd2;
    localparam logic [1:0] ST_NO_FRAMES  = 2'd3;

    // Build a table entry from a frame number and request flags
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FN_W-1:0] fn,
                                                      input logic [7:0] fl);
        make_entry = {fl[7], 11'b0, fn, 4'b0, fl[6], 1'b0, fl[5:0]};
    endfunction

endpackage

`default_nettype wire

### src/four_level_page_table_engine_top.sv
// Four-level page table engine: walk, map and unmap over a single-port table store.
// Each level visited passes through a read state, then an evaluate state with optional
//   write back; a request is accepted in idle and its result registered in finish.
// A new request is taken only in idle, once the last result has entered the output register.
// Reset: a clearing pass zeroes every entry of the table store, one entry a cycle;
//   no request is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_engine_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [flpte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [3:0]                      cfg_data,
    // Request channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      req_type,
    input  wire logic [flpte_pkg::VA_W-1:0]      virt_address,
    input  wire logic [flpte_pkg::PA_W-1:0]      frame_addr,
    input  wire logic [7:0]                      flags,
    // Result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [flpte_pkg::PA_W-1:0]           phys_addr,
    output logic [1:0]                           status,
    output logic                                 flush_page
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    // Registers
    state_t                               state_reg, state_next;
    logic [flpte_pkg::ADDR_W-1:0]         clr_reg, clr_next;
    logic [3:0]                           root_reg;
    logic [flpte_pkg::NF_W-1:0]           next_free_reg, next_free_next;
    logic [1:0]                           level_reg, level_next;
    logic [flpte_pkg::FRAME_W-1:0]        frame_reg, frame_next;
    logic [1:0]                           req_reg, req_next;
    logic [flpte_pkg::VA_W-1:0]           va_reg, va_next;
    logic [flpte_pkg::PA_W-1:0]           fa_reg, fa_next;
    logic [7:0]                           fl_reg, fl_next;
    logic [flpte_pkg::PA_W-1:0]           res_pa_reg, res_pa_next;
    logic [1:0]                           res_st_reg, res_st_next;
    logic                                 res_fl_reg, res_fl_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [flpte_pkg::PA_W-1:0]           phys_addr_reg, phys_addr_next;
    logic [1:0]                           status_reg, status_next;
    logic                                 flush_reg, flush_next;

    // Table store port
    logic [flpte_pkg::ENTRY_W-1:0]        mem
                                          [flpte_pkg::NUM_FRAMES * flpte_pkg::ENTRIES_PER_TABLE];
    logic [flpte_pkg::ADDR_W-1:0]         mem_addr;
    logic                                 mem_we;
    logic [flpte_pkg::ENTRY_W-1:0]        mem_wdata;
    logic [flpte_pkg::ENTRY_W-1:0]        mem_rdata;

    logic [flpte_pkg::IDX_W-1:0]          idx;
    logic [flpte_pkg::FN_W-1:0]           rd_fn;
    logic                                 nf_exhausted;
    logic                                 cfg_fire;
    logic                                 in_fire;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid & cfg_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid & in_ready;
    assign out_valid  = out_valid_reg;
    assign phys_addr  = phys_addr_reg;
    assign status     = status_reg;
    assign flush_page = flush_reg;

    assign rd_fn        = mem_rdata[51:12];
    assign nf_exhausted = (next_free_reg == '0) ||
                          (next_free_reg >= flpte_pkg::NF_W'(flpte_pkg::NUM_FRAMES));

    // Select the table index of the current level
    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    // Sequence the walk and drive the store port
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        next_free_next = next_free_reg;
        level_next     = level_reg;
        frame_next     = frame_reg;
        req_next       = req_reg;
        va_next        = va_reg;
        fa_next        = fa_reg;
        fl_next        = fl_reg;
        res_pa_next    = res_pa_reg;
        res_st_next    = res_st_reg;
        res_fl_next    = res_fl_reg;
        out_valid_next = out_valid_reg;
        phys_addr_next = phys_addr_reg;
        status_next    = status_reg;
        flush_next     = flush_reg;
        mem_addr       = {frame_reg, idx};
        mem_we         = 1'b0;
        mem_wdata      = '0;

        // Drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {flpte_pkg::ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next    = req_type;
                    va_next     = virt_address;
                    fa_next     = frame_addr;
                    fl_next     = flags;
                    level_next  = 2'd0;
                    frame_next  = flpte_pkg::FRAME_W'(root_reg);
                    res_pa_next = '0;
                    res_st_next = flpte_pkg::ST_OK;
                    res_fl_next = 1'b0;
                    if (req_type == flpte_pkg::REQ_TRANSLATE ||
                        req_type == flpte_pkg::REQ_MAP ||
                        req_type == flpte_pkg::REQ_UNMAP)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (req_reg)
                    flpte_pkg::REQ_TRANSLATE:
                    begin
                        if (rd_fn == '0)
                        begin
                            res_st_next = flpte_pkg::ST_NOT_MAPPED;
                            state_next  = S_FINISH;
                        end
                        else if (level_reg == 2'd3)
                        begin
                            res_pa_next = {rd_fn, 12'b0};
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            frame_next = flpte_pkg::FRAME_W'(rd_fn);
                            level_next = level_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    flpte_pkg::REQ_MAP:
                    begin
                        if (level_reg == 2'd3)
                        begin
                            if (mem_rdata[0])
                            begin
                                res_st_next = flpte_pkg::ST_ALREADY;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = flpte_pkg::make_entry(fa_reg[51:12], fl_reg);
                                res_fl_next = 1'b1;
                            end
                            state_next = S_FINISH;
                        end
                        else if (mem_rdata[0])
                        begin
                            frame_next = flpte_pkg::FRAME_W'(rd_fn);
                            level_next = level_reg + 1'b1;
                            state_next = S_READ;
                        end
                        else if (nf_exhausted)
                        begin
                            res_st_next = flpte_pkg::ST_NO_FRAMES;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            // Allocate a fresh table and descend into it
                            mem_we         = 1'b1;
                            mem_wdata      = flpte_pkg::make_entry(
                                                 flpte_pkg::FN_W'(next_free_reg), fl_reg);
                            next_free_next = next_free_reg + 1'b1;
                            frame_next     = flpte_pkg::FRAME_W'(next_free_reg);
                            level_next     = level_reg + 1'b1;
                            state_next     = S_READ;
                        end
                    end
                    default:
                    begin
                        if (level_reg == 2'd3)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '0;
                            res_fl_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else if (mem_rdata[0])
                        begin
                            frame_next = flpte_pkg::FRAME_W'(rd_fn);
                            level_next = level_reg + 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            res_st_next = flpte_pkg::ST_NOT_MAPPED;
                            state_next  = S_FINISH;
                        end
                    end
                endcase
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    phys_addr_next = res_pa_reg;
                    status_next    = res_st_reg;
                    flush_next     = res_fl_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Reload the allocator on a configuration write to CFG_FIRST_FREE
        if (cfg_fire && cfg_index == flpte_pkg::CFG_FIRST_FREE)
        begin
            next_free_next = flpte_pkg::NF_W'(cfg_data);
        end
    end

    // Hold state, configuration and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            root_reg      <= 4'd0;
            next_free_reg <= flpte_pkg::NF_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire && cfg_index == flpte_pkg::CFG_ROOT_FRAME)
            begin
                root_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        level_reg     <= level_next;
        frame_reg     <= frame_next;
        req_reg       <= req_next;
        va_reg        <= va_next;
        fa_reg        <= fa_next;
        fl_reg        <= fl_next;
        res_pa_reg    <= res_pa_next;
        res_st_reg    <= res_st_next;
        res_fl_reg    <= res_fl_next;
        phys_addr_reg <= phys_addr_next;
        status_reg    <= status_next;
        flush_reg     <= flush_next;
    end

    // Table store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

endmodule

`default_nettype wire
